@@ rtl/bdq_pkg.sv @@
// ============================================================================
// bdq_pkg: shared types and codes of the bounded deque
// Command and status codes, the data width and the result record that the
// sequencer hands to the output stage.
// ============================================================================
package bdq_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes carried by an input item.
    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_SEARCH     = 3'd4;

    // Status codes carried by a result item.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // Result record from the sequencer; the count travels beside it since
    // its width follows the depth.
    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     found;
        status_t                  status;
    } result_t;

endpackage

@@ rtl/bdq_ram.sv @@
// ============================================================================
// bdq_ram: element store of the deque
// Single write port and single read port; the read data is registered.
// ============================================================================
module bdq_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/bdq_seq.sv @@
// ============================================================================
// bdq_seq: sequencer of the deque
// Holds the front position and the count, drives the store and walks the
// held elements one per cycle through a single comparator for a search.
// ============================================================================
module bdq_seq
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res,
    output logic [CNT_W-1:0]         res_count,
    output logic                     mem_we,
    output logic [IDX_W-1:0]         mem_waddr,
    output logic signed [DATA_W-1:0] mem_wdata,
    output logic                     mem_re,
    output logic [IDX_W-1:0]         mem_raddr,
    input  logic signed [DATA_W-1:0] mem_rdata
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POPRD = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]         scan_addr_reg, scan_addr_next;
    cmd_t                     cmd_reg, cmd_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    result_t                  res_reg, res_next;

    logic [CNT_W-1:0] offset;
    logic [SUM_W-1:0] ring_sum;
    logic [IDX_W-1:0] ring_addr;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] scan_inc;
    logic             is_full;
    logic             is_empty;
    logic             hit;

    // Ring address unit: front plus an offset, wrapped once.
    always_comb
    begin
        offset    = (cmd_reg == CMD_POP_BACK) ? (count_reg - CNT_W'(1)) : count_reg;
        ring_sum  = SUM_W'(front_reg) + SUM_W'(offset);
        ring_addr = (ring_sum >= SUM_W'(DEPTH)) ? IDX_W'(ring_sum - SUM_W'(DEPTH))
                                                : IDX_W'(ring_sum);
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
        scan_inc  = (scan_addr_reg == LAST_IDX) ? '0 : scan_addr_reg + IDX_W'(1);
        is_full   = (count_reg == FULL_CNT);
        is_empty  = (count_reg == '0);
        hit       = (mem_rdata == value_reg);
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        scan_addr_next = scan_addr_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = ring_addr;
        mem_wdata      = value_reg;
        mem_re         = 1'b0;
        mem_raddr      = ring_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    value_next = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next.popped_value = '0;
                res_next.found        = 1'b0;
                res_next.status       = ST_OK;
                state_next            = S_DONE;
                case (cmd_reg)
                    CMD_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = front_dec;
                            front_next = front_dec;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = (cmd_reg == CMD_POP_FRONT) ? front_reg : ring_addr;
                            state_next = S_POPRD;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (!is_empty)
                        begin
                            mem_re         = 1'b1;
                            mem_raddr      = front_reg;
                            scan_addr_next = front_reg;
                            scan_idx_next  = '0;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_POPRD:
            begin
                res_next.popped_value = mem_rdata;
                count_next            = count_reg - CNT_W'(1);
                if (cmd_reg == CMD_POP_FRONT)
                begin
                    front_next = front_inc;
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                // One held element per cycle through the comparator.
                if (hit)
                begin
                    res_next.found = 1'b1;
                    state_next     = S_DONE;
                end
                else if (scan_idx_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_inc;
                    scan_addr_next = scan_inc;
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            scan_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            scan_addr_reg <= scan_addr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign res_count = count_reg;

`ifndef SYNTH
    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("deque count above depth");

    // The front position stays inside the ring.
    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= LAST_IDX)
        else $error("front position outside ring");

    // A scan only visits held elements.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg < count_reg))
        else $error("scan index beyond held elements");

    // A push into a queue that is not full adds exactly one element.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !is_full &&
         (cmd_reg == CMD_PUSH_FRONT || cmd_reg == CMD_PUSH_BACK))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not add one element");

    // The count holds while a search runs.
    a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(count_reg))
        else $error("count changed during search");
`endif

endmodule

@@ rtl/bounded_deque_with_search.sv @@
// ============================================================================
// bounded_deque_with_search: bounded double-ended queue with value search
// Ring store of DEPTH signed 32-bit elements with push and pop at both ends
// and a linear search that compares one held element per cycle.
// ============================================================================
// From accept to result valid, a push or an unused command passes through the
// execute step only, a pop adds a step that takes the store's registered read,
// and a search reads held elements until a match or the last (none if empty).
// A new item is accepted only once the last result has left the sequencer,
// whose steps, the store's registered read and the one comparator set the pace.
// Reset (rst_n low, asynchronous) empties the queue and clears all control
// state; the store itself is not cleared and needs no clearing pass.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cmd_t                           cmd,
    input  logic signed [DATA_W-1:0]       value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [DATA_W-1:0]       popped_value,
    output logic                           found,
    output logic [$clog2(DEPTH + 1)-1:0]   count,
    output status_t                        status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     res_valid;
    logic                     res_ready;
    result_t                  res;
    logic [CNT_W-1:0]         res_count;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    logic                     out_valid_reg, out_valid_next;
    result_t                  out_res_reg;
    logic [CNT_W-1:0]         out_count_reg;

    bdq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_count (res_count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: takes a finished item when it is empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg   <= res;
            out_count_reg <= res_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_res_reg.popped_value;
    assign found        = out_res_reg.found;
    assign status       = out_res_reg.status;
    assign count        = out_count_reg;

endmodule

@@ test/bounded_deque_with_search_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bounded_deque_with_search_tb: self-checking bench for the bounded deque
// Drives push, pop, search and unused commands through the valid/ready input
// channel in random bursts. A local model of the ring store predicts every
// result item. The output channel stalls on its own changing pattern. A short
// directed sequence covers empty and full refusals and the value extremes.
// ============================================================================
module bounded_deque_with_search_tb;
    import bdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1020;
    localparam int DRAIN_EVERY = 250;
    localparam int SETTLE_CYCLES = 25;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_CAP  = 100;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // Command codes the block treats as no operation.
    localparam cmd_t CMD_UNUSED_LO  = 3'd5;
    localparam cmd_t CMD_UNUSED_MID = 3'd6;
    localparam cmd_t CMD_UNUSED_HI  = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        cmd_t                     op;
        logic signed [DATA_W-1:0] data;
        int                       gap;
        bit                       drain;
    } deque_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] popped_value;
        logic                     found;
        logic [CNT_W-1:0]         count;
        status_t                  status;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    cmd_t                     cmd = CMD_PUSH_FRONT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [CNT_W-1:0]         count;
    status_t                  status;

    // Stimulus and scoreboard storage.
    deque_item_t   cmd_items[$];
    deque_result_t awaited_results[$];
    int            mismatches = 0;
    bit            item_taken = 1'b0;

    // Local copy of the deque contents.
    logic signed [DATA_W-1:0] ring [DEPTH];
    int                       head = 0;
    int                       held = 0;

    // Sender burst shaping, used while the item list is built.
    int burst_left = 0;
    int burst_gap = 0;
    logic signed [DATA_W-1:0] recent [8];
    int recent_idx = 0;

    bounded_deque_with_search #(.DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .found        (found),
        .count        (count),
        .status       (status)
    );

    always #6 clk = ~clk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_CAP)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Applies one accepted command to the local deque and queues its result.
    task automatic predict_deque_op(input cmd_t op, input logic signed [DATA_W-1:0] v);
        deque_result_t r;
        r.popped_value = '0;
        r.found = 1'b0;
        r.status = ST_OK;
        case (op)
            CMD_PUSH_FRONT:
            begin
                if (held >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = v;
                    held++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    ring[(head + held) % DEPTH] = v;
                    held++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.popped_value = ring[head];
                    head = (head + 1) % DEPTH;
                    held--;
                end
            end
            CMD_POP_BACK:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.popped_value = ring[(head + held - 1) % DEPTH];
                    held--;
                end
            end
            CMD_SEARCH:
            begin
                for (int i = 0; i < held; i++)
                begin
                    if (ring[(head + i) % DEPTH] == v)
                    begin
                        r.found = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(held);
        awaited_results.push_back(r);
    endtask

    // Appends one item; the first item of each sender burst carries the burst's idle gap.
    task automatic add_item(input cmd_t op, input logic signed [DATA_W-1:0] v,
                            input bit drain);
        deque_item_t it;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(20, 1);
            burst_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
            it.gap = burst_gap;
        end
        else
        begin
            it.gap = 0;
        end
        burst_left--;
        it.op = op;
        it.data = v;
        it.drain = drain;
        if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK)
        begin
            recent[recent_idx] = v;
            recent_idx = (recent_idx + 1) % 8;
        end
        cmd_items.push_back(it);
    endtask

    // Values lean on a small range so that searches hit often.
    function automatic logic signed [DATA_W-1:0] pick_value(input bit for_search);
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (for_search && sel < 55)
        begin
            return recent[$urandom_range(7, 0)];
        end
        if (sel < 60)
        begin
            return $signed($urandom_range(16, 0)) - 8;
        end
        if (sel < 65)
        begin
            return ($urandom_range(1, 0) == 1) ? VAL_MAX : VAL_MIN;
        end
        return $signed($urandom);
    endfunction

    // Builds the directed part and the random part of the stimulus.
    initial
    begin
        int unsigned roll;
        int          bias;
        cmd_t        op;
        for (int i = 0; i < 8; i++)
        begin
            recent[i] = '0;
        end

        // Refusals and search on the empty queue.
        add_item(CMD_POP_FRONT, 32'sd5, 1'b0);
        add_item(CMD_POP_BACK, 32'sd7, 1'b0);
        add_item(CMD_SEARCH, '0, 1'b0);
        // Extremes at both ends, then hit and miss searches.
        add_item(CMD_PUSH_FRONT, VAL_MIN, 1'b0);
        add_item(CMD_PUSH_BACK, VAL_MAX, 1'b0);
        add_item(CMD_SEARCH, VAL_MAX, 1'b0);
        add_item(CMD_SEARCH, -32'sd1, 1'b0);
        add_item(CMD_UNUSED_LO, 32'sd3, 1'b0);
        add_item(CMD_POP_BACK, '0, 1'b0);
        // Fill up to the limit, then try both pushes on the full queue.
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            add_item((i % 2 == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $signed($urandom), 1'b0);
        end
        add_item(CMD_PUSH_FRONT, 32'sd11, 1'b0);
        add_item(CMD_PUSH_BACK, 32'sd12, 1'b0);
        add_item(CMD_SEARCH, VAL_MIN, 1'b0);
        add_item(CMD_UNUSED_MID, '1, 1'b0);
        add_item(CMD_UNUSED_HI, '0, 1'b0);

        // Random part: phases that grow, shrink or hold the queue.
        bias = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                bias = $urandom_range(3, 0);
            end
            roll = $urandom_range(99, 0);
            if (roll < 3)
            begin
                op = cmd_t'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            end
            else if (roll < 20)
            begin
                op = CMD_SEARCH;
            end
            else
            begin
                roll = $urandom_range(99, 0);
                case (bias)
                    0: op = (roll < 75) ? CMD_PUSH_FRONT : CMD_POP_FRONT;
                    1: op = (roll < 25) ? CMD_PUSH_BACK : CMD_POP_BACK;
                    default: op = (roll < 50) ? CMD_PUSH_BACK : CMD_POP_FRONT;
                endcase
                // Mix the ends so every pairing of push and pop occurs.
                if ($urandom_range(1, 0) == 1)
                begin
                    op = cmd_t'(op ^ 3'd1);
                end
            end
            add_item(op, pick_value(op == CMD_SEARCH), (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
        end
    end

    // Reset sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Input driver: takes the next pending item after the previous is accepted.
    deque_item_t cur;
    bit          have_cur = 1'b0;
    int          gap_left = 0;
    int          settle_left = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !item_taken))
        begin
            if (!have_cur && cmd_items.size() > 0)
            begin
                cur = cmd_items.pop_front();
                have_cur = 1'b1;
                gap_left = cur.gap;
                settle_left = SETTLE_CYCLES;
            end
            if (have_cur && gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (have_cur && cur.drain &&
                     (awaited_results.size() > 0 || settle_left > 0))
            begin
                // Hold off until every result is out and the block is quiet.
                if (awaited_results.size() == 0)
                begin
                    settle_left--;
                end
                in_valid <= 1'b0;
            end
            else if (have_cur)
            begin
                in_valid <= 1'b1;
                cmd <= cur.op;
                value <= cur.data;
                have_cur = 1'b0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: segments of free flow, random, sparse and long stalls.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(3, 0);
            stall_left = $urandom_range(200, 20);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(1, 0));
            2: out_ready <= (stall_phase % 4) == 0;
            default: out_ready <= (stall_phase % 32) >= 24;
        endcase
    end

    // Monitor: checks result items and feeds accepted items to the predictor.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            item_taken <= 1'b0;
        end
        else
        begin
            item_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result item with nothing awaited, count %0d",
                                              count));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (popped_value !== want.popped_value)
                        report_mismatch($sformatf("popped_value %0d, wanted %0d",
                                                  popped_value, want.popped_value));
                    if (found !== want.found)
                        report_mismatch($sformatf("found %b, wanted %b", found, want.found));
                    if (count !== want.count)
                        report_mismatch($sformatf("count %0d, wanted %0d", count, want.count));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  status, want.status));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_deque_op(cmd, value);
            end
        end
    end

    // End of run: all items accepted, all results in, then a quiet tail.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (cmd_items.size() > 0 || have_cur || in_valid || awaited_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
        begin
            $display("bounded_deque_with_search_tb passed");
        end
        else
        begin
            $display("bounded_deque_with_search_tb failed");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #(TIMEOUT_NS);
        $display("bounded_deque_with_search_tb failed");
        $finish;
    end

endmodule
